// File: sv/vip_pkg.sv
package vip_pkg;

   localparam int VOXEL_W    = 16;
   localparam int MODE_W     = 2;
   localparam int DIM_XY_W   = 9;
   localparam int DIM_Z_W    = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;
   localparam int DIV_STEPS  = 2;
   localparam int DIV_STAGES = VOXEL_W / DIV_STEPS;

   // projection kinds; the unused code acts as maximum
   localparam logic [MODE_W-1:0] MODE_MAX    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MIN    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_AVG    = 2'd2;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIM_X = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIM_Y = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIM_Z = 2'd3;

   localparam logic [MODE_W-1:0]   MODE_RESET  = MODE_MAX;
   localparam logic [DIM_XY_W-1:0] DIM_X_RESET = 9'd256;
   localparam logic [DIM_XY_W-1:0] DIM_Y_RESET = 9'd256;
   localparam logic [DIM_Z_W-1:0]  DIM_Z_RESET = 11'd128;

   // control that travels with the accumulator value
   typedef struct packed {
      logic valid;
      logic avg;
      logic last_pixel;
   } acc_ctl_type;

   // one beat inside the divider pipeline
   typedef struct packed {
      logic                 valid;
      logic                 avg;
      logic                 last_pixel;
      logic [DIM_Z_W-1:0]   rem;
      logic [VOXEL_W-1:0]   num;
   } div_stage_type;

endpackage

// File: sv/vip_req_if.sv
interface vip_req_if;
   logic                        valid;
   logic                        ready;
   logic [vip_pkg::VOXEL_W-1:0] voxel;

   modport source (output valid, output voxel, input ready);
   modport sink (input valid, input voxel, output ready);
endinterface

// File: sv/vip_rsp_if.sv
interface vip_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [vip_pkg::VOXEL_W-1:0] projected;
   logic                        last_pixel;

   modport source (output valid, output projected, output last_pixel, input ready);
   modport sink (input valid, input projected, input last_pixel, output ready);
endinterface

// File: sv/volume_intensity_projection_core.sv
// Maximum, minimum or floored average intensity projection of a volume.
//
// req_beat carries one 16-bit voxel per beat, slice after slice, each slice
// row by row. Every voxel updates the accumulator of its pixel through one
// read-modify-write of an on-chip memory of MAX_ROWS*MAX_COLS words. Beats
// of the last slice each produce one rsp_beat with the projected value;
// last_pixel marks the final pixel of the image. Other slices produce none.
//
// Throughput is one voxel per cycle while rsp_beat does not stall. An
// accepted voxel passes memory read, update, range check, then eight stages
// of a pipelined divider that retire two quotient bits each.
//
// The csr_ port writes mode, dim_x, dim_y and dim_z by index; write only
// while no beat is in flight. Synchronous reset clears the counters, the
// valid bits and the registers to their defaults; the accumulator memory
// needs no clearing, since the first slice loads it.
// When rsp_beat stalls, stages fill up behind the output register and
// req_beat.ready drops only once the whole pipeline is full.
module volume_intensity_projection_core #(
   parameter int MAX_ROWS   = 256,
   parameter int MAX_COLS   = 256,
   parameter int MAX_SLICES = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   vip_req_if.sink                         req_beat,
   vip_rsp_if.source                       rsp_beat,
   input  logic                            csr_we,
   input  logic [vip_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [vip_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int SLW = $clog2(MAX_SLICES + 1);
   localparam int AW  = vip_pkg::VOXEL_W + SLW;
   localparam int HW  = AW - vip_pkg::VOXEL_W;

   logic [vip_pkg::MODE_W-1:0]   mode_ff;
   logic [vip_pkg::DIM_XY_W-1:0] dim_x_ff;
   logic [vip_pkg::DIM_XY_W-1:0] dim_y_ff;
   logic [vip_pkg::DIM_Z_W-1:0]  dim_z_ff;

   logic [vip_pkg::DIM_XY_W-1:0] nx;
   logic [vip_pkg::DIM_XY_W-1:0] ny;
   logic [vip_pkg::DIM_Z_W-1:0]  nz;

   vip_pkg::acc_ctl_type acc_ctl;
   logic [AW-1:0]        acc_val;
   logic                 acc_ready;

   vip_pkg::div_stage_type prep_ff;
   vip_pkg::div_stage_type prep_in;
   logic                   prep_ready;

   logic [HW-1:0] acc_hi;

   vip_pkg::div_stage_type div_data [vip_pkg::DIV_STAGES+1];
   logic                   div_ready [vip_pkg::DIV_STAGES+1];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= vip_pkg::MODE_RESET;
         dim_x_ff <= vip_pkg::DIM_X_RESET;
         dim_y_ff <= vip_pkg::DIM_Y_RESET;
         dim_z_ff <= vip_pkg::DIM_Z_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            vip_pkg::CSR_MODE:  mode_ff  <= csr_wdata[vip_pkg::MODE_W-1:0];
            vip_pkg::CSR_DIM_X: dim_x_ff <= csr_wdata[vip_pkg::DIM_XY_W-1:0];
            vip_pkg::CSR_DIM_Y: dim_y_ff <= csr_wdata[vip_pkg::DIM_XY_W-1:0];
            vip_pkg::CSR_DIM_Z: dim_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamp dimensions: zero acts as one, large values saturate
   always_comb begin
      if (dim_x_ff == '0) nx = vip_pkg::DIM_XY_W'(1);
      else if (int'(dim_x_ff) > MAX_ROWS) nx = vip_pkg::DIM_XY_W'(MAX_ROWS);
      else nx = dim_x_ff;
      if (dim_y_ff == '0) ny = vip_pkg::DIM_XY_W'(1);
      else if (int'(dim_y_ff) > MAX_COLS) ny = vip_pkg::DIM_XY_W'(MAX_COLS);
      else ny = dim_y_ff;
      if (dim_z_ff == '0) nz = vip_pkg::DIM_Z_W'(1);
      else if (int'(dim_z_ff) > MAX_SLICES) nz = vip_pkg::DIM_Z_W'(MAX_SLICES);
      else nz = dim_z_ff;
   end

   vip_accum #(
      .MAX_ROWS   (MAX_ROWS),
      .MAX_COLS   (MAX_COLS),
      .MAX_SLICES (MAX_SLICES),
      .SLW        (SLW),
      .AW         (AW)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_beat.valid),
      .in_voxel  (req_beat.voxel),
      .in_ready  (req_beat.ready),
      .mode      (mode_ff),
      .nx        (nx),
      .ny        (ny),
      .nz        (nz),
      .out_ctl   (acc_ctl),
      .out_acc   (acc_val),
      .out_ready (acc_ready)
   );

   // range check: saturate results above full scale, seed the divider
   assign acc_hi = acc_val[AW-1:vip_pkg::VOXEL_W];

   always_comb begin
      prep_in.valid      = acc_ctl.valid;
      prep_in.last_pixel = acc_ctl.last_pixel;
      prep_in.avg        = 1'b0;
      prep_in.rem        = '0;
      prep_in.num        = acc_val[vip_pkg::VOXEL_W-1:0];
      if (acc_ctl.avg) begin
         if (int'(acc_hi) >= int'(nz)) begin
            prep_in.num = '1;
         end else begin
            prep_in.avg = 1'b1;
            prep_in.rem = vip_pkg::DIM_Z_W'(acc_hi);
         end
      end else if (acc_hi != '0) begin
         prep_in.num = '1;
      end
   end

   assign acc_ready = !prep_ff.valid || prep_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ff.valid <= 1'b0;
      end else if (acc_ready) begin
         prep_ff.valid <= prep_in.valid;
      end
      if (acc_ready) begin
         prep_ff.avg        <= prep_in.avg;
         prep_ff.last_pixel <= prep_in.last_pixel;
         prep_ff.rem        <= prep_in.rem;
         prep_ff.num        <= prep_in.num;
      end
   end

   // divider pipeline; its last stage is the output register
   assign div_data[0] = prep_ff;
   assign prep_ready  = div_ready[0];

   for (genvar k = 0; k < vip_pkg::DIV_STAGES; k++) begin : g_div
      vip_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .nz        (nz),
         .in_data   (div_data[k]),
         .in_ready  (div_ready[k]),
         .out_data  (div_data[k+1]),
         .out_ready (div_ready[k+1])
      );
   end

   assign div_ready[vip_pkg::DIV_STAGES] = rsp_beat.ready;
   assign rsp_beat.valid      = div_data[vip_pkg::DIV_STAGES].valid;
   assign rsp_beat.projected  = div_data[vip_pkg::DIV_STAGES].num;
   assign rsp_beat.last_pixel = div_data[vip_pkg::DIV_STAGES].last_pixel;

endmodule

// File: sv/vip_accum.sv
module vip_accum #(
   parameter int MAX_ROWS   = 256,
   parameter int MAX_COLS   = 256,
   parameter int MAX_SLICES = 1024,
   parameter int SLW        = $clog2(MAX_SLICES + 1),
   parameter int AW         = vip_pkg::VOXEL_W + SLW
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [vip_pkg::VOXEL_W-1:0]   in_voxel,
   output logic                          in_ready,
   input  logic [vip_pkg::MODE_W-1:0]    mode,
   input  logic [vip_pkg::DIM_XY_W-1:0]  nx,
   input  logic [vip_pkg::DIM_XY_W-1:0]  ny,
   input  logic [vip_pkg::DIM_Z_W-1:0]   nz,
   output vip_pkg::acc_ctl_type          out_ctl,
   output logic [AW-1:0]                 out_acc,
   input  logic                          out_ready
);

   localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int ADW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [AW-1:0] mem [DEPTH];

   logic [CW-1:0]  col_ff, col_in;
   logic [RW-1:0]  row_ff, row_in;
   logic [SLW-1:0] slc_ff, slc_in;

   logic                        v1_ff;
   logic [vip_pkg::VOXEL_W-1:0] voxel1_ff;
   logic [ADW-1:0]              addr1_ff;
   logic                        first1_ff;
   logic                        lslice1_ff;
   logic                        lpix1_ff;
   logic [AW-1:0]               rd_ff;
   logic                        fwd_ff;
   logic [AW-1:0]               fwd_acc_ff;

   vip_pkg::acc_ctl_type ctl2_ff;
   logic [AW-1:0]        acc2_ff;

   logic           accept;
   logic           s1_adv;
   logic [ADW-1:0] addr;
   logic           last_col;
   logic           last_row;
   logic           last_slice;
   logic [AW-1:0]  acc_old;
   logic [AW-1:0]  acc_new;
   logic [AW-1:0]  vox_ext;

   assign s1_adv   = !ctl2_ff.valid || out_ready;
   assign in_ready = !v1_ff || s1_adv;
   assign accept   = in_valid && in_ready;

   // locate the pixel and detect the ends of row, slice and volume
   assign addr       = ADW'(int'(row_ff) * MAX_COLS + int'(col_ff));
   assign last_col   = (int'(col_ff) + 1) >= int'(ny);
   assign last_row   = (int'(row_ff) + 1) >= int'(nx);
   assign last_slice = (int'(slc_ff) + 1) >= int'(nz);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      slc_in = slc_ff;
      if (last_col) begin
         col_in = '0;
         if (last_row) begin
            row_in = '0;
            slc_in = last_slice ? '0 : slc_ff + 1'b1;
         end else begin
            row_in = row_ff + 1'b1;
         end
      end else begin
         col_in = col_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         slc_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
         slc_ff <= slc_in;
      end
   end

   // combine the voxel with the stored value, taking a just-written value first
   assign vox_ext = AW'(voxel1_ff);
   assign acc_old = fwd_ff ? fwd_acc_ff : rd_ff;

   always_comb begin
      if (first1_ff) begin
         acc_new = vox_ext;
      end else begin
         case (mode)
            vip_pkg::MODE_MIN: acc_new = (vox_ext < acc_old) ? vox_ext : acc_old;
            vip_pkg::MODE_AVG: acc_new = acc_old + vox_ext;
            default:           acc_new = (vox_ext > acc_old) ? vox_ext : acc_old;
         endcase
      end
   end

   // read stage: load the beat and fetch its accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (in_ready) begin
         v1_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         voxel1_ff  <= in_voxel;
         addr1_ff   <= addr;
         first1_ff  <= (slc_ff == '0);
         lslice1_ff <= last_slice;
         lpix1_ff   <= last_row && last_col;
         rd_ff      <= mem[addr];
         fwd_ff     <= v1_ff && (addr1_ff == addr);
         fwd_acc_ff <= acc_new;
      end
   end

   // write back the updated accumulator as the beat leaves
   always_ff @(posedge clock) begin
      if (v1_ff && s1_adv) begin
         mem[addr1_ff] <= acc_new;
      end
   end

   // pass on only beats of the last slice
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff.valid <= 1'b0;
      end else if (s1_adv) begin
         ctl2_ff.valid <= v1_ff && lslice1_ff;
      end
      if (s1_adv) begin
         ctl2_ff.avg        <= (mode == vip_pkg::MODE_AVG);
         ctl2_ff.last_pixel <= lpix1_ff;
         acc2_ff            <= acc_new;
      end
   end

   assign out_ctl = ctl2_ff;
   assign out_acc = acc2_ff;

endmodule

// File: sv/vip_div_step.sv
module vip_div_step (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [vip_pkg::DIM_Z_W-1:0]  nz,
   input  vip_pkg::div_stage_type       in_data,
   output logic                         in_ready,
   output vip_pkg::div_stage_type       out_data,
   input  logic                         out_ready
);

   vip_pkg::div_stage_type stage_ff;
   vip_pkg::div_stage_type stage_in;

   logic [vip_pkg::DIM_Z_W:0]   shifted;
   logic                        ge;
   logic [vip_pkg::DIM_Z_W-1:0] rem;
   logic [vip_pkg::VOXEL_W-1:0] num;

   assign in_ready = !stage_ff.valid || out_ready;

   // two restoring division steps on average beats; the remainder stays below nz
   always_comb begin
      rem = in_data.rem;
      num = in_data.num;
      shifted = '0;
      ge = 1'b0;
      if (in_data.avg) begin
         for (int i = 0; i < vip_pkg::DIV_STEPS; i++) begin
            shifted = {rem, num[vip_pkg::VOXEL_W-1]};
            ge      = shifted >= {1'b0, nz};
            rem     = ge ? vip_pkg::DIM_Z_W'(shifted - {1'b0, nz})
                         : shifted[vip_pkg::DIM_Z_W-1:0];
            num     = {num[vip_pkg::VOXEL_W-2:0], ge};
         end
      end
      stage_in     = in_data;
      stage_in.rem = rem;
      stage_in.num = num;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (in_ready) begin
         stage_ff.valid <= in_data.valid;
      end
      if (in_ready) begin
         stage_ff.avg        <= stage_in.avg;
         stage_ff.last_pixel <= stage_in.last_pixel;
         stage_ff.rem        <= stage_in.rem;
         stage_ff.num        <= stage_in.num;
      end
   end

   assign out_data = stage_ff;

endmodule
